/* rtl/imap_command_tokenizer_core_defines.svh */
// Assertion macros shared by the tokenizer checker.
// Each macro expects clk and arst_n in scope.
`ifndef IMAP_COMMAND_TOKENIZER_CORE_DEFINES_SVH
`define IMAP_COMMAND_TOKENIZER_CORE_DEFINES_SVH

// Same-cycle implication, muted during reset.
`define ICT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, muted during reset.
`define ICT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/imap_tok_pkg.sv */
// ----------------------------------------------------------------------------
// imap_tok_pkg
// Types, codes and limits shared by the command line tokenizer modules.
// ----------------------------------------------------------------------------
package imap_tok_pkg;

	localparam int TAG_MAX     = 64;
	localparam int COMMAND_MAX = 32;
	localparam int ARGS_MAX    = 1024;

	localparam int TAG_W = $clog2(TAG_MAX);
	localparam int CMD_W = $clog2(COMMAND_MAX);
	localparam int ARG_W = $clog2(ARGS_MAX);

	// parser phases
	localparam logic [2:0] PH_LEAD      = 3'd0;
	localparam logic [2:0] PH_TAG       = 3'd1;
	localparam logic [2:0] PH_GAP1      = 3'd2;
	localparam logic [2:0] PH_CMD       = 3'd3;
	localparam logic [2:0] PH_GAP2      = 3'd4;
	localparam logic [2:0] PH_ARGS      = 3'd5;
	localparam logic [2:0] PH_END_EMPTY = 3'd6;
	localparam logic [2:0] PH_END       = 3'd7;

	// result kinds
	localparam logic [1:0] KIND_TAG = 2'd0;
	localparam logic [1:0] KIND_CMD = 2'd1;
	localparam logic [1:0] KIND_ARG = 2'd2;
	localparam logic [1:0] KIND_SUM = 2'd3;

	// summary status
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_NO_TAG = 2'd2;
	localparam logic [1:0] ST_NO_CMD = 2'd3;

	typedef struct packed {
		logic [2:0]       phase;
		logic             first;
		logic [TAG_W-1:0] tag_cnt;
		logic [CMD_W-1:0] cmd_cnt;
		logic [ARG_W-1:0] arg_idx;
		logic [ARG_W-1:0] arg_trim;
	} tok_state_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [9:0] pos;
		logic [1:0] status;
		logic [5:0] tag_len;
		logic [4:0] cmd_len;
		logic [9:0] arg_len;
		logic       last;
	} tok_res_t;

	typedef struct packed {
		logic push_byte;
		logic push_sum;
	} tok_push_t;

	function automatic tok_state_t tok_line_start();
		tok_state_t s;
		s          = '0;
		s.phase    = PH_LEAD;
		s.first    = 1'b1;
		return s;
	endfunction

endpackage

/* rtl/imap_command_tokenizer_core.sv */
// Path: a kept byte goes from the input register through the parser into the
// result queue, which offers it at the output. Throughput: one input byte per
// cycle while the queue has room; the last byte of a line that also keeps a byte
// yields two output beats, which the two-entry result queue absorbs.
// Reset: clears the input register and result queue and returns the parser to
// line start; payload registers are not reset.
// ----------------------------------------------------------------------------
// imap_command_tokenizer_core
// Splits a byte stream of IMAP command lines into tag, command and argument
// beats plus one summary beat per line.
// ----------------------------------------------------------------------------
module imap_command_tokenizer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] line_byte,
	input  logic       line_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] item_kind,
	output logic [7:0] field_byte,
	output logic [9:0] field_position,
	output logic [1:0] parse_status,
	output logic [5:0] tag_length,
	output logic [4:0] command_length,
	output logic [9:0] args_length,
	output logic       run_last
);

	logic                     valid_s1;
	logic [7:0]               byte_s1;
	logic                     end_s1;
	imap_tok_pkg::tok_state_t state_q, state_nxt;
	logic                     byte_valid, sum_valid;
	imap_tok_pkg::tok_res_t   byte_res, sum_res, head;
	imap_tok_pkg::tok_push_t  push;
	logic [1:0]               free, need;
	logic                     advance;

	imap_tok_step u_step (
		.st        (state_q),
		.data      (byte_s1),
		.last      (end_s1),
		.nst       (state_nxt),
		.byte_valid(byte_valid),
		.byte_res  (byte_res),
		.sum_valid (sum_valid),
		.sum_res   (sum_res)
	);

	assign need    = 2'(byte_valid) + 2'(sum_valid);
	assign advance = valid_s1 && (need <= free);
	assign in_ready = !valid_s1 || advance;

	assign push.push_byte = advance && byte_valid;
	assign push.push_sum  = advance && sum_valid;

	imap_tok_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.d_byte   (byte_res),
		.d_sum    (sum_res),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.head     (head),
		.free     (free)
	);

	// hold the beat in the input register until the queue has room
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= line_byte;
			end_s1  <= line_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= imap_tok_pkg::tok_line_start();
		end else begin
			if (in_valid && in_ready) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance) state_q <= state_nxt;
		end
	end

	assign item_kind      = head.kind;
	assign field_byte     = head.data;
	assign field_position = head.pos;
	assign parse_status   = head.status;
	assign tag_length     = head.tag_len;
	assign command_length = head.cmd_len;
	assign args_length    = head.arg_len;
	assign run_last       = head.last;

endmodule

/* rtl/imap_tok_step.sv */
// ----------------------------------------------------------------------------
// imap_tok_step
// Per-byte parser logic: next parser state, optional byte result and the
// line summary on the last byte.
// ----------------------------------------------------------------------------
module imap_tok_step (
	input  imap_tok_pkg::tok_state_t st,
	input  logic [7:0]               data,
	input  logic                     last,
	output imap_tok_pkg::tok_state_t nst,
	output logic                     byte_valid,
	output imap_tok_pkg::tok_res_t   byte_res,
	output logic                     sum_valid,
	output imap_tok_pkg::tok_res_t   sum_res
);

	logic sp;

	assign sp = (data == 8'h20) || (data inside {[8'h09:8'h0D]});

	always_comb begin
		logic [2:0] ph;
		logic       done;
		nst        = st;
		byte_valid = 1'b0;
		byte_res   = '0;
		sum_valid  = 1'b0;
		sum_res    = '0;
		ph         = st.phase;
		done       = 1'b0;

		if (st.phase != imap_tok_pkg::PH_END && st.phase != imap_tok_pkg::PH_END_EMPTY) begin
			if (data == 8'h00) begin
				nst.phase = st.first ? imap_tok_pkg::PH_END_EMPTY : imap_tok_pkg::PH_END;
			end else begin
				nst.first = 1'b0;
				if (ph == imap_tok_pkg::PH_LEAD) begin
					if (sp) done = 1'b1;
					else ph = imap_tok_pkg::PH_TAG;
				end
				if (!done && ph == imap_tok_pkg::PH_TAG) begin
					if (sp) begin
						ph   = imap_tok_pkg::PH_GAP1;
						done = 1'b1;
					end else if (st.tag_cnt <
						imap_tok_pkg::TAG_W'(imap_tok_pkg::TAG_MAX - 1)) begin
						byte_valid    = 1'b1;
						byte_res.kind = imap_tok_pkg::KIND_TAG;
						byte_res.data = data;
						byte_res.pos  = 10'(st.tag_cnt);
						nst.tag_cnt   = st.tag_cnt + imap_tok_pkg::TAG_W'(1);
						done          = 1'b1;
					end else begin
						// tag full: spill straight into the command
						ph = imap_tok_pkg::PH_CMD;
					end
				end
				if (!done && ph == imap_tok_pkg::PH_GAP1) begin
					if (sp) done = 1'b1;
					else ph = imap_tok_pkg::PH_CMD;
				end
				if (!done && ph == imap_tok_pkg::PH_CMD) begin
					if (sp) begin
						ph   = imap_tok_pkg::PH_GAP2;
						done = 1'b1;
					end else if (st.cmd_cnt <
						imap_tok_pkg::CMD_W'(imap_tok_pkg::COMMAND_MAX - 1)) begin
						byte_valid    = 1'b1;
						byte_res.kind = imap_tok_pkg::KIND_CMD;
						byte_res.data = (data inside {[8'h61:8'h7A]}) ? data - 8'h20 : data;
						byte_res.pos  = 10'(st.cmd_cnt);
						nst.cmd_cnt   = st.cmd_cnt + imap_tok_pkg::CMD_W'(1);
						done          = 1'b1;
					end else begin
						ph = imap_tok_pkg::PH_ARGS;
					end
				end
				if (!done && ph == imap_tok_pkg::PH_GAP2) begin
					if (sp) done = 1'b1;
					else ph = imap_tok_pkg::PH_ARGS;
				end
				if (!done && ph == imap_tok_pkg::PH_ARGS) begin
					if (st.arg_idx < imap_tok_pkg::ARG_W'(imap_tok_pkg::ARGS_MAX - 1)) begin
						byte_valid    = 1'b1;
						byte_res.kind = imap_tok_pkg::KIND_ARG;
						byte_res.data = data;
						byte_res.pos  = 10'(st.arg_idx);
						nst.arg_idx   = st.arg_idx + imap_tok_pkg::ARG_W'(1);
						if (!sp) nst.arg_trim = st.arg_idx + imap_tok_pkg::ARG_W'(1);
					end
				end
				nst.phase = ph;
			end
		end

		if (last) begin
			sum_valid    = 1'b1;
			sum_res.kind = imap_tok_pkg::KIND_SUM;
			sum_res.last = 1'b1;
			if (nst.phase == imap_tok_pkg::PH_END_EMPTY) begin
				sum_res.status = imap_tok_pkg::ST_EMPTY;
			end else begin
				if (nst.tag_cnt == '0) sum_res.status = imap_tok_pkg::ST_NO_TAG;
				else if (nst.cmd_cnt == '0) sum_res.status = imap_tok_pkg::ST_NO_CMD;
				else sum_res.status = imap_tok_pkg::ST_OK;
				sum_res.tag_len = 6'(nst.tag_cnt);
				sum_res.cmd_len = 5'(nst.cmd_cnt);
				sum_res.arg_len = 10'(nst.arg_trim);
			end
			nst = imap_tok_pkg::tok_line_start();
		end

		byte_res.last = byte_valid && !last;
	end

endmodule

/* rtl/imap_tok_outq.sv */
// ----------------------------------------------------------------------------
// imap_tok_outq
// Two-entry result queue; takes up to two results per cycle in order and
// hands out one beat per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module imap_tok_outq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  imap_tok_pkg::tok_push_t push,
	input  imap_tok_pkg::tok_res_t d_byte,
	input  imap_tok_pkg::tok_res_t d_sum,
	input  logic                   out_ready,
	output logic                   out_valid,
	output imap_tok_pkg::tok_res_t head,
	output logic [1:0]             free
);

	imap_tok_pkg::tok_res_t slot0_q, slot1_q;
	logic       wr_q, rd_q;
	logic [1:0] count_q;
	logic       pop;
	logic       sum_ptr;

	assign out_valid = (count_q != 2'd0);
	assign head      = rd_q ? slot1_q : slot0_q;
	assign free      = 2'd2 - count_q;
	assign pop       = out_valid && out_ready;
	assign sum_ptr   = wr_q ^ push.push_byte;

	always_ff @(posedge clk) begin
		if (push.push_byte) begin
			if (wr_q) slot1_q <= d_byte;
			else slot0_q <= d_byte;
		end
		if (push.push_sum) begin
			if (sum_ptr) slot1_q <= d_sum;
			else slot0_q <= d_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			wr_q    <= wr_q ^ push.push_byte ^ push.push_sum;
			rd_q    <= rd_q ^ pop;
			count_q <= count_q + 2'(push.push_byte) + 2'(push.push_sum) - 2'(pop);
		end
	end

endmodule

/* rtl/imap_tok_checker.sv */
// ----------------------------------------------------------------------------
// imap_tok_checker
// Port-level checks on the tokenizer output channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "imap_command_tokenizer_core_defines.svh"

module imap_tok_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] item_kind,
	input logic [7:0] field_byte,
	input logic [9:0] field_position,
	input logic [1:0] parse_status,
	input logic [5:0] tag_length,
	input logic [4:0] command_length,
	input logic [9:0] args_length,
	input logic       run_last
);

	`ICT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "output beat dropped while stalled")
	`ICT_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(item_kind) && $stable(field_byte) && $stable(field_position) && $stable(args_length), "stalled output beat changed")
	`ICT_ASSERT_IMP(a_sum_last, out_valid && item_kind == imap_tok_pkg::KIND_SUM, run_last, "summary beat not marked last")
	`ICT_ASSERT_IMP(a_byte_clean, out_valid && item_kind != imap_tok_pkg::KIND_SUM, parse_status == imap_tok_pkg::ST_OK && tag_length == 6'd0 && command_length == 5'd0 && args_length == 10'd0, "byte beat carries summary fields")
	`ICT_ASSERT_IMP(a_empty_zero, out_valid && item_kind == imap_tok_pkg::KIND_SUM && parse_status == imap_tok_pkg::ST_EMPTY, tag_length == 6'd0 && command_length == 5'd0 && args_length == 10'd0 && field_byte == 8'd0, "empty line summary with lengths")

endmodule

bind imap_command_tokenizer_core imap_tok_checker u_imap_tok_checker (.*);

/* sim/tb_imap_command_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// tb_imap_command_tokenizer_core
// Feeds command lines byte by byte into the tokenizer core and checks every
// tag, command, argument and summary beat against a line parser kept in step.
// ----------------------------------------------------------------------------
module tb_imap_command_tokenizer_core;

	typedef struct {
		logic [7:0] b;
		logic       fin;
	} line_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] line_byte = 8'h00;
	logic       line_end = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] item_kind;
	logic [7:0] field_byte;
	logic [9:0] field_position;
	logic [1:0] parse_status;
	logic [5:0] tag_length;
	logic [4:0] command_length;
	logic [9:0] args_length;
	logic       run_last;

	line_beat_t             pending_beats[$];
	logic [7:0]             line_buf[$];
	imap_tok_pkg::tok_res_t expected_beats[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int holds_asked = 0;
	int holds_served = 0;
	int hold_left = 0;
	int mismatches = 0;
	int live_items = 0;
	bit line_zeroed = 1'b0;

	// parser shadow state
	logic [2:0] tk_phase;
	logic       tk_fresh;
	int         tk_tag_cnt;
	int         tk_cmd_cnt;
	int         tk_arg_idx;
	int         tk_arg_trim;

	imap_command_tokenizer_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.line_byte      (line_byte),
		.line_end       (line_end),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.item_kind      (item_kind),
		.field_byte     (field_byte),
		.field_position (field_position),
		.parse_status   (parse_status),
		.tag_length     (tag_length),
		.command_length (command_length),
		.args_length    (args_length),
		.run_last       (run_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic imap_tok_pkg::tok_res_t mk_beat(logic [1:0] kind, logic [7:0] data,
			int pos, logic [1:0] st, int tl, int cl, int al);
		imap_tok_pkg::tok_res_t r;
		r.kind    = kind;
		r.data    = data;
		r.pos     = 10'(pos);
		r.status  = st;
		r.tag_len = 6'(tl);
		r.cmd_len = 5'(cl);
		r.arg_len = 10'(al);
		r.last    = 1'b0;
		return r;
	endfunction

	task automatic line_start();
		tk_phase    = imap_tok_pkg::PH_LEAD;
		tk_fresh    = 1'b1;
		tk_tag_cnt  = 0;
		tk_cmd_cnt  = 0;
		tk_arg_idx  = 0;
		tk_arg_trim = 0;
	endtask

	// Advance the shadow parser by one byte and queue the beats it yields.
	task automatic tokenize_byte(input logic [7:0] b, input logic fin);
		imap_tok_pkg::tok_res_t beats[2];
		int                     n;
		logic                   sp;
		logic                   done;
		logic [7:0]             up;
		logic [1:0]             st;
		n    = 0;
		done = 1'b0;
		sp   = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
		up   = (b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
		if (tk_phase != imap_tok_pkg::PH_END && tk_phase != imap_tok_pkg::PH_END_EMPTY) begin
			if (b == 8'h00) begin
				tk_phase = tk_fresh ? imap_tok_pkg::PH_END_EMPTY : imap_tok_pkg::PH_END;
			end else begin
				tk_fresh = 1'b0;
				if (tk_phase == imap_tok_pkg::PH_LEAD) begin
					if (sp)
						done = 1'b1;
					else
						tk_phase = imap_tok_pkg::PH_TAG;
				end
				if (!done && tk_phase == imap_tok_pkg::PH_TAG) begin
					if (sp) begin
						tk_phase = imap_tok_pkg::PH_GAP1;
						done = 1'b1;
					end else if (tk_tag_cnt < imap_tok_pkg::TAG_MAX - 1) begin
						beats[n] = mk_beat(imap_tok_pkg::KIND_TAG, b, tk_tag_cnt,
							imap_tok_pkg::ST_OK, 0, 0, 0);
						n++;
						tk_tag_cnt++;
						done = 1'b1;
					end else begin
						// full tag spills straight into the command
						tk_phase = imap_tok_pkg::PH_CMD;
					end
				end
				if (!done && tk_phase == imap_tok_pkg::PH_GAP1) begin
					if (sp)
						done = 1'b1;
					else
						tk_phase = imap_tok_pkg::PH_CMD;
				end
				if (!done && tk_phase == imap_tok_pkg::PH_CMD) begin
					if (sp) begin
						tk_phase = imap_tok_pkg::PH_GAP2;
						done = 1'b1;
					end else if (tk_cmd_cnt < imap_tok_pkg::COMMAND_MAX - 1) begin
						beats[n] = mk_beat(imap_tok_pkg::KIND_CMD, up, tk_cmd_cnt,
							imap_tok_pkg::ST_OK, 0, 0, 0);
						n++;
						tk_cmd_cnt++;
						done = 1'b1;
					end else begin
						tk_phase = imap_tok_pkg::PH_ARGS;
					end
				end
				if (!done && tk_phase == imap_tok_pkg::PH_GAP2) begin
					if (sp)
						done = 1'b1;
					else
						tk_phase = imap_tok_pkg::PH_ARGS;
				end
				if (!done && tk_phase == imap_tok_pkg::PH_ARGS &&
						tk_arg_idx < imap_tok_pkg::ARGS_MAX - 1) begin
					beats[n] = mk_beat(imap_tok_pkg::KIND_ARG, b, tk_arg_idx,
						imap_tok_pkg::ST_OK, 0, 0, 0);
					n++;
					tk_arg_idx++;
					if (!sp)
						tk_arg_trim = tk_arg_idx;
				end
			end
		end
		if (fin) begin
			if (tk_phase == imap_tok_pkg::PH_END_EMPTY)
				st = imap_tok_pkg::ST_EMPTY;
			else if (tk_tag_cnt == 0)
				st = imap_tok_pkg::ST_NO_TAG;
			else if (tk_cmd_cnt == 0)
				st = imap_tok_pkg::ST_NO_CMD;
			else
				st = imap_tok_pkg::ST_OK;
			if (st == imap_tok_pkg::ST_EMPTY)
				beats[n] = mk_beat(imap_tok_pkg::KIND_SUM, 8'h00, 0, st, 0, 0, 0);
			else
				beats[n] = mk_beat(imap_tok_pkg::KIND_SUM, 8'h00, 0, st, tk_tag_cnt,
					tk_cmd_cnt, tk_arg_trim);
			n++;
			line_start();
		end
		if (n > 0)
			beats[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			expected_beats.push_back(beats[i]);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// driver: take the next line byte from the pending queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			line_byte <= 8'h00;
			line_end  <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				tokenize_byte(line_byte, line_end);
			if (!in_valid || in_ready) begin
				if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid  <= 1'b1;
					line_byte <= pending_beats[0].b;
					line_end  <= pending_beats[0].fin;
					pending_beats.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, requested by the stimulus
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left    <= 0;
			holds_served <= 0;
		end else if (holds_served != holds_asked) begin
			hold_left    <= 400;
			holds_served <= holds_served + 1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor: compare each result beat with the oldest expectation
	always @(posedge clk or negedge arst_n) begin : result_monitor
		imap_tok_pkg::tok_res_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_beats.size() == 0) begin
					$display("%0t: unexpected beat, expected none, got kind %0d byte %0d",
						$time, item_kind, field_byte);
					mismatches++;
				end else begin
					want = expected_beats.pop_front();
					check_field("item_kind", want.kind, item_kind);
					check_field("field_byte", want.data, field_byte);
					check_field("field_position", want.pos, field_position);
					check_field("parse_status", want.status, parse_status);
					check_field("tag_length", want.tag_len, tag_length);
					check_field("command_length", want.cmd_len, command_length);
					check_field("args_length", want.arg_len, args_length);
					check_field("run_last", want.last, run_last);
				end
			end
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic logic [7:0] ws_byte();
		int v;
		v = $urandom_range(8, 13);
		return (v == 8) ? 8'h20 : 8'(v);
	endfunction

	// non-whitespace, non-zero byte; letters and digits unless any value is asked for
	function automatic logic [7:0] word_byte(bit any_val);
		logic [7:0] v;
		if (!any_val) begin
			case ($urandom_range(2))
				0: v = 8'(8'h61 + $urandom_range(25));
				1: v = 8'(8'h41 + $urandom_range(25));
				default: v = 8'(8'h30 + $urandom_range(9));
			endcase
		end else begin
			v = 8'(1 + $urandom_range(254));
			while (v == 8'h20 || (v >= 8'h09 && v <= 8'h0D))
				v = 8'(1 + $urandom_range(254));
		end
		return v;
	endfunction

	task automatic put_byte(input logic [7:0] b);
		line_buf.push_back(b);
		// bytes after a zero are ignored by the block; do not count them
		if (!line_zeroed)
			live_items++;
		if (b == 8'h00)
			line_zeroed = 1'b1;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	task automatic put_ws(input int n);
		repeat (n) put_byte(ws_byte());
	endtask

	task automatic put_word(input int n, input bit any_val);
		repeat (n) put_byte(word_byte(any_val));
	endtask

	task automatic commit_line();
		line_beat_t lb;
		for (int i = 0; i < line_buf.size(); i++) begin
			lb.b   = line_buf[i];
			lb.fin = (i == line_buf.size() - 1);
			pending_beats.push_back(lb);
		end
		line_buf.delete();
		line_zeroed = 1'b0;
	endtask

	task automatic random_line();
		int r;
		r = $urandom_range(99);
		if (r < 70) begin
			put_ws($urandom_range(0, 2));
			put_word(($urandom_range(39) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8),
				$urandom_range(3) == 0);
			put_ws($urandom_range(1, 3));
			put_word(($urandom_range(29) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 10),
				$urandom_range(7) == 0);
			repeat ($urandom_range(0, 3)) begin
				put_ws($urandom_range(1, 2));
				put_word($urandom_range(1, 12), $urandom_range(1) == 1);
			end
			if ($urandom_range(3) == 0)
				put_ws($urandom_range(1, 3));
			if ($urandom_range(9) == 0) begin
				put_byte(8'h00);
				repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(255)));
			end
		end else if (r < 85) begin
			case ($urandom_range(3))
				0: put_ws($urandom_range(1, 3));
				1: begin
					put_ws($urandom_range(0, 2));
					put_word($urandom_range(1, 6), 1'b0);
				end
				2: begin
					put_word($urandom_range(1, 6), 1'b1);
					put_ws($urandom_range(1, 3));
				end
				default: put_byte(8'h00);
			endcase
		end else begin
			repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(255)));
		end
		commit_line();
	endtask

	task automatic random_phase(input int n_items);
		int start;
		start = live_items;
		while (live_items - start < n_items)
			random_line();
	endtask

	task automatic drain_input();
		while (pending_beats.size() != 0 || in_valid)
			@(negedge clk);
	endtask

	initial begin : stimulus
		int k;
		line_start();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		put_text("a1 login user pass");
		commit_line();
		put_byte(8'h00);
		commit_line();
		put_text(" \t ");
		put_byte(8'h0B);
		commit_line();
		put_text("tag");
		commit_line();
		put_text("tag2 \t");
		commit_line();
		put_text("\t t2 select  inbox  \t\r\n");
		commit_line();
		put_text("x noop");
		put_byte(8'h00);
		put_text("junk 1");
		commit_line();
		put_byte(8'h00);
		put_text("ab c");
		commit_line();
		// byte extremes and the edges of the whitespace and lowercase ranges
		put_byte(8'hFF);
		put_byte(8'h80);
		put_byte(8'h01);
		put_byte(8'h7F);
		put_byte(8'h0C);
		put_text("`az{@[AZ");
		put_byte(8'h0D);
		put_byte(8'h08);
		put_byte(8'h0E);
		put_byte(8'h20);
		put_byte(8'h09);
		commit_line();
		repeat (70) put_byte("t");
		put_text(" c x");
		commit_line();
		put_text("t ");
		repeat (40) put_byte("q");
		put_text(" y");
		commit_line();
		drain_input();

		// hold the receiver off while bytes keep coming
		holds_asked++;
		random_phase(160);
		drain_input();

		send_idle_pct = 77;
		random_phase(160);
		drain_input();

		send_idle_pct  = 0;
		recv_stall_pct = 77;
		random_phase(160);
		drain_input();

		send_idle_pct  = 35;
		recv_stall_pct = 35;
		random_phase(162);
		drain_input();

		for (k = 0; k < 20000 && expected_beats.size() != 0; k++)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (expected_beats.size() != 0) begin
			$display("%0t: %0d expected beats never arrived, got none", $time,
				expected_beats.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin : watchdog
		#5000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
